// ----- src/tccs_pkg.sv -----
// shared types, codes and constants of the text console cursor and scroll unit
`default_nettype none

package tccs_pkg;

	// screen geometry defaults
	localparam int DEF_COLUMNS     = 80;
	localparam int DEF_ROWS        = 25;
	localparam int DEF_QUEUE_DEPTH = 2;

	// field widths
	localparam int MODE_W = 3;
	localparam int BYTE_W = 8;
	localparam int OCOL_W = 7;
	localparam int OROW_W = 5;

	// request modes as they arrive
	localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BKSP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

	// decoded operations handed to the back end
	typedef logic [2:0] op_t;
	localparam op_t OP_PUT  = 3'd0;
	localparam op_t OP_NL   = 3'd1;
	localparam op_t OP_BS   = 3'd2;
	localparam op_t OP_CLR  = 3'd3;
	localparam op_t OP_SET  = 3'd4;
	localparam op_t OP_RD   = 3'd5;
	localparam op_t OP_NOP  = 3'd6;

	// character and attribute constants
	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'd7;

	// classified request in the queue
	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] col;
		logic [BYTE_W-1:0] row;
	} cmd_t;

	// result as it leaves the back end
	typedef struct packed {
		logic [OCOL_W-1:0] cursor_col;
		logic [OROW_W-1:0] cursor_row;
		logic [BYTE_W-1:0] cell_char;
		logic [BYTE_W-1:0] cell_attr;
	} res_t;

endpackage

`default_nettype wire

// ----- src/tccs_ifs.sv -----
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface tccs_cmd_if import tccs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] char_code;
	logic [BYTE_W-1:0] col;
	logic [BYTE_W-1:0] row;

	modport source (output valid, mode, char_code, col, row, input ready);
	modport sink (input valid, mode, char_code, col, row, output ready);
endinterface

interface tccs_res_if import tccs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OCOL_W-1:0] cursor_col;
	logic [OROW_W-1:0] cursor_row;
	logic [BYTE_W-1:0] cell_char;
	logic [BYTE_W-1:0] cell_attr;

	modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr, output ready);
endinterface

interface tccs_cfg_if import tccs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- src/tccs_front.sv -----
// front end: takes requests, decodes the mode and clamps coordinates
`default_nettype none

module tccs_front import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	tccs_cmd_if.sink cmd,
	input  wire  init_busy,
	input  wire  q_full,
	output logic q_push,
	output cmd_t q_data
);

	localparam logic [BYTE_W-1:0] LAST_COL = BYTE_W'(COLUMNS - 1);
	localparam logic [BYTE_W-1:0] LAST_ROW = BYTE_W'(ROWS - 1);

	assign cmd.ready = !q_full && !init_busy;
	assign q_push    = cmd.valid && cmd.ready;

	always_comb begin
		q_data.ch  = cmd.char_code;
		q_data.col = (cmd.col > LAST_COL) ? LAST_COL : cmd.col;
		q_data.row = (cmd.row > LAST_ROW) ? LAST_ROW : cmd.row;
		case (cmd.mode)
			MODE_PUT:   q_data.op = (cmd.char_code == NEWLINE_CODE) ? OP_NL : OP_PUT;
			MODE_BKSP:  q_data.op = OP_BS;
			MODE_CLEAR: q_data.op = OP_CLR;
			MODE_SET:   q_data.op = OP_SET;
			MODE_READ:  q_data.op = OP_RD;
			default:    q_data.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/tccs_queue.sv -----
// short fifo of decoded requests between front and back end
`default_nettype none

module tccs_queue import tccs_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  cmd_t push_data,
	output logic full,
	input  wire  pop,
	output logic pop_valid,
	output cmd_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ----- src/tccs_back.sv -----
// back end: cursor, row ring, screen memory and result register
`default_nettype none

module tccs_back import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [BYTE_W-1:0] fill_attr,
	input  wire               q_valid,
	input  cmd_t              q_data,
	output logic              q_pop,
	output logic              init_busy,
	output logic              res_valid,
	input  wire               res_ready,
	output res_t              res_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int MW    = 16;
	localparam logic [BYTE_W-1:0] LAST_COL  = BYTE_W'(COLUMNS - 1);
	localparam logic [BYTE_W-1:0] LAST_ROW  = BYTE_W'(ROWS - 1);
	localparam logic [AW-1:0]     LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0]     ROW_CELLS = AW'(COLUMNS);
	localparam logic [AW-1:0]     ROW_LASTC = AW'(COLUMNS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADDR   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_CLEAR  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic              init_q;
	logic [BYTE_W-1:0] col_q;
	logic [BYTE_W-1:0] row_q;
	logic [BYTE_W-1:0] top_q;
	logic [AW-1:0]     top_base_q;
	logic [AW-1:0]     cnt_q;
	cmd_t              cmd_q;
	logic [BYTE_W-1:0] pr_q;
	logic [BYTE_W-1:0] tc_q;
	logic [BYTE_W-1:0] tr_q;
	logic [AW-1:0]     addr_q;
	logic [BYTE_W-1:0] rd_char_q;
	logic [BYTE_W-1:0] rd_attr_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [BYTE_W-1:0] char_mem [CELLS];
	logic [BYTE_W-1:0] attr_mem [CELLS];

	logic              origin;
	logic              load_res;
	logic [BYTE_W-1:0] tgt_row;
	logic [BYTE_W-1:0] tgt_col;
	logic [BYTE_W:0]   row_sum;
	logic [BYTE_W:0]   phys_row;
	logic [MW-1:0]     lin_addr;
	logic              char_we;
	logic              attr_we;
	logic [AW-1:0]     waddr;
	logic [BYTE_W-1:0] wchar;
	logic [BYTE_W-1:0] wattr;

	assign origin    = (col_q == '0) && (row_q == '0);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign init_busy = init_q;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign load_res  = (state_q == S_DONE) && (!res_valid_q || res_ready);

	// logical target cell of the request at the head of the queue
	always_comb begin
		tgt_row = row_q;
		tgt_col = col_q;
		case (q_data.op)
			OP_BS: begin
				if (col_q == '0) begin
					tgt_row = row_q - 1'b1;
					tgt_col = LAST_COL;
				end else begin
					tgt_col = col_q - 1'b1;
				end
			end
			OP_RD: begin
				tgt_row = q_data.row;
				tgt_col = q_data.col;
			end
			default: ;
		endcase
		row_sum  = {1'b0, tgt_row} + {1'b0, top_q};
		phys_row = (row_sum >= (BYTE_W+1)'(ROWS)) ? row_sum - (BYTE_W+1)'(ROWS) : row_sum;
		lin_addr = MW'(pr_q) * MW'(COLUMNS) + MW'(tc_q);
	end

	// single write port shared by put, backspace, scroll and clear
	always_comb begin
		char_we = 1'b0;
		attr_we = 1'b0;
		waddr   = addr_q;
		wchar   = SPACE_CODE;
		wattr   = fill_attr;
		case (state_q)
			S_EXEC: begin
				if (cmd_q.op == OP_PUT) begin
					char_we = 1'b1;
					wchar   = cmd_q.ch;
				end else if (cmd_q.op == OP_BS && !origin) begin
					char_we = 1'b1;
					attr_we = 1'b1;
				end
			end
			S_SCROLL: begin
				char_we = 1'b1;
				attr_we = 1'b1;
				waddr   = top_base_q + cnt_q;
			end
			S_CLEAR: begin
				char_we = 1'b1;
				attr_we = 1'b1;
				waddr   = cnt_q;
				wattr   = init_q ? RESET_ATTR : fill_attr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (char_we) char_mem[waddr] <= wchar;
		if (attr_we) attr_mem[waddr] <= wattr;
		rd_char_q <= char_mem[addr_q];
		rd_attr_q <= attr_mem[addr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
			pr_q  <= phys_row[BYTE_W-1:0];
			tc_q  <= tgt_col;
			tr_q  <= tgt_row;
		end
		if (state_q == S_ADDR) addr_q <= lin_addr[AW-1:0];
		if (load_res) begin
			res_q.cursor_col <= col_q[OCOL_W-1:0];
			res_q.cursor_row <= row_q[OROW_W-1:0];
			res_q.cell_char  <= (cmd_q.op == OP_RD) ? rd_char_q : '0;
			res_q.cell_attr  <= (cmd_q.op == OP_RD) ? rd_attr_q : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			top_base_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_valid) state_q <= S_ADDR;
				end
				S_ADDR: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					cnt_q   <= '0;
					case (cmd_q.op)
						OP_PUT: begin
							if (col_q == LAST_COL) begin
								col_q <= '0;
								if (row_q == LAST_ROW) state_q <= S_SCROLL;
								else                   row_q   <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
						OP_NL: begin
							col_q <= '0;
							if (row_q == LAST_ROW) state_q <= S_SCROLL;
							else                   row_q   <= row_q + 1'b1;
						end
						OP_BS: begin
							if (!origin) begin
								col_q <= tc_q;
								row_q <= tr_q;
							end
						end
						OP_CLR: begin
							col_q      <= '0;
							row_q      <= '0;
							top_q      <= '0;
							top_base_q <= '0;
							state_q    <= S_CLEAR;
						end
						OP_SET: begin
							col_q <= cmd_q.col;
							row_q <= cmd_q.row;
						end
						default: ;
					endcase
				end
				S_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROW_LASTC) begin
						// the blanked oldest row becomes the new bottom row
						if (top_q == LAST_ROW) begin
							top_q      <= '0;
							top_base_q <= '0;
						end else begin
							top_q      <= top_q + 1'b1;
							top_base_q <= top_base_q + ROW_CELLS;
						end
						state_q <= S_DONE;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_DONE: begin
					if (load_res) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/text_console_cursor_scroll_unit.sv -----
// top level of the text console cursor and scroll unit
//
// usage
// - cmd channel: one request per handshake (mode, char_code, col, row); put,
//   newline, backspace, clear, set cursor (clamped), read cell (clamped)
// - res channel: exactly one result per request, in request order, with the
//   cursor after the request and the addressed cell for a read, else zeros
// - cfg channel: writes fill_attr, the attribute of blanked cells; always ready
// - a request enters a two-deep queue on acceptance, so the front keeps taking
//   requests while the back end works or the result waits to be taken
// - a plain request passes the back-end sequencer in four steps (pop, address
//   multiply, memory access, result load), and the back end pops the next
//   request only after the result of the last one is loaded
// - a scroll writes one blank per cell of the oldest row, which
//   is then recycled as the bottom row through a top-row pointer, no copying
// - a clear makes one memory write per cell
// - reset: a clearing pass fills the
//   screen with spaces in attribute 7; no request is taken during it
// - a stalled result holds in the output register; the back end then waits and
//   the queue fills, after which cmd.ready drops
`default_nettype none

module text_console_cursor_scroll_unit import tccs_pkg::*; #(
	parameter int COLUMNS     = DEF_COLUMNS,
	parameter int ROWS        = DEF_ROWS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input wire       clk,
	input wire       arst_n,
	tccs_cmd_if.sink cmd,
	tccs_res_if.source res,
	tccs_cfg_if.sink cfg
);

	logic [BYTE_W-1:0] fill_attr_q;
	logic              init_busy;
	logic              q_full;
	logic              q_push;
	cmd_t              q_in;
	logic              q_valid;
	cmd_t              q_out;
	logic              q_pop;
	res_t              res_data;

	// fill attribute register, written whenever a cfg request arrives
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        fill_attr_q <= RESET_ATTR;
		else if (cfg.valid) fill_attr_q <= cfg.data;
	end

	// decode and clamp
	tccs_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.cmd       (cmd),
		.init_busy (init_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	// decouples the front from the back end
	tccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_out)
	);

	// cursor, screen memory and result
	tccs_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fill_attr (fill_attr_q),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res_data)
	);

	assign res.cursor_col = res_data.cursor_col;
	assign res.cursor_row = res_data.cursor_row;
	assign res.cell_char  = res_data.cell_char;
	assign res.cell_attr  = res_data.cell_attr;

	// no request taken during the clearing pass
	a_no_req_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !cmd.ready)
		else $error("request accepted during clearing pass");

	// no result can come out before the screen is initialized
	a_no_res_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !res.valid)
		else $error("result produced during clearing pass");

	// back end pops only an occupied queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire
